[rtl/mlr_pkg.sv]
// Shared types and constants for the midpoint line rasterizer.
// Holds the command codes, decision test codes and controller/datapath structs.
package mlr_pkg;

    localparam int COORD_BITS_DEF = 6;

    localparam logic CMD_MOVE = 1'b0;
    localparam logic CMD_LINE = 1'b1;

    typedef enum logic [1:0] {
        DEC_GE0 = 2'b00,
        DEC_LT0 = 2'b01,
        DEC_GT0 = 2'b10
    } dec_test_t;

    typedef struct packed {
        logic load_move;
        logic load_line;
        logic setup;
        logic step;
    } mlr_ctl_t;

    typedef struct packed {
        logic zero_len;
        logic last_step;
        logic out_free;
    } mlr_sts_t;

endpackage

[rtl/midpoint_line_rasterizer_unit.sv]
// Midpoint line rasterizer top level: controller and datapath.
// Depends on mlr_pkg, mlr_ctrl and mlr_datapath.
//
// Request channel (cmd_valid/cmd_stall, cmd, x_coord, y_coord): cmd 0 moves the
// current point, cmd 1 draws a line from the current point to the target.
// Pixel channel (pixel_valid/pixel_stall, pixel_x, pixel_y, last_pixel): one
// request per plotted pixel, last_pixel set on the final one of each line.
// A move updates the current point. A line passes through a setup state, then
// yields one pixel per cycle while the receiver takes them, n pixels in all,
// where n is the longer axis span (up to 2^COORD_BITS - 1). Setup loads the
// walk; the first step loads the first pixel into the output register. A
// zero-length line passes through setup and emits nothing. The rate is set by
// the single walk unit, which advances one step a cycle while the output is
// free. The next request is taken once the last pixel of a line is in the
// output register. pixel_stall with a pixel held keeps it there and pauses
// the walk. Reset sets the current point to the origin and empties the output.
module midpoint_line_rasterizer_unit #(
    parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_stall,
    input  logic                  cmd,
    input  logic [COORD_BITS-1:0] x_coord,
    input  logic [COORD_BITS-1:0] y_coord,
    output logic                  pixel_valid,
    input  logic                  pixel_stall,
    output logic [COORD_BITS-1:0] pixel_x,
    output logic [COORD_BITS-1:0] pixel_y,
    output logic                  last_pixel
);
    import mlr_pkg::*;

    mlr_ctl_t ctl;
    mlr_sts_t sts;

    mlr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_stall (cmd_stall),
        .sts       (sts),
        .ctl       (ctl)
    );

    mlr_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .x_coord     (x_coord),
        .y_coord     (y_coord),
        .ctl         (ctl),
        .sts         (sts),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .last_pixel  (last_pixel)
    );

endmodule

[rtl/mlr_ctrl.sv]
// Controller state machine for the midpoint line rasterizer.
// Depends on mlr_pkg; drives commands to mlr_datapath and reads its status.
module mlr_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    input  logic            cmd,
    output logic            cmd_stall,
    input  mlr_pkg::mlr_sts_t sts,
    output mlr_pkg::mlr_ctl_t ctl
);
    import mlr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SETUP = 3'b010,
        ST_RUN   = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd == CMD_LINE)
                    begin
                        ctl.load_line = 1'b1;
                        state_next    = ST_SETUP;
                    end
                    else
                    begin
                        ctl.load_move = 1'b1;
                    end
                end
            end
            ST_SETUP:
            begin
                ctl.setup  = 1'b1;
                state_next = sts.zero_len ? ST_IDLE : ST_RUN;
            end
            ST_RUN:
            begin
                if (sts.out_free)
                begin
                    ctl.step = 1'b1;
                    if (sts.last_step)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign cmd_stall = (state_reg != ST_IDLE);

    a_setup_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SETUP) |=> (state_reg != ST_SETUP))
        else $error("setup held for more than one cycle");

    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.step && sts.last_step) |=> (state_reg == ST_IDLE))
        else $error("walk did not end after last step");

    a_zero_len_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SETUP && sts.zero_len) |=> (state_reg == ST_IDLE))
        else $error("zero-length line entered walk");

endmodule

[rtl/mlr_datapath.sv]
// Datapath for the midpoint line rasterizer: current point, octant setup,
// decision-variable walk and pixel output register. Depends on mlr_pkg.
module mlr_datapath #(
    parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [COORD_BITS-1:0] x_coord,
    input  logic [COORD_BITS-1:0] y_coord,
    input  mlr_pkg::mlr_ctl_t     ctl,
    output mlr_pkg::mlr_sts_t     sts,
    output logic                  pixel_valid,
    input  logic                  pixel_stall,
    output logic [COORD_BITS-1:0] pixel_x,
    output logic [COORD_BITS-1:0] pixel_y,
    output logic                  last_pixel
);
    import mlr_pkg::*;

    localparam int W  = COORD_BITS;
    localparam int DW = COORD_BITS + 4;

    logic [W-1:0] cur_x_reg, cur_y_reg;
    logic [W-1:0] tgt_x_reg, tgt_y_reg;
    logic [W-1:0] walk_x_reg, walk_y_reg;
    logic [W-1:0] cnt_reg;
    logic signed [DW-1:0] d_reg, inc_a_reg, inc_b_reg;
    dec_test_t test_reg;
    logic major_y_reg, major_dec_reg, minor_dec_reg;
    logic out_valid_reg, out_valid_next;
    logic [W-1:0] pix_x_reg, pix_y_reg;
    logic pix_last_reg;

    logic signed [W:0] dxr, dyr, adx, ady, odx, ody;
    logic dx_zero, dy_zero, dx_pos, dy_pos, same_sign;
    logic oct_sr, oct_shr, oct_shf, major_y, swap;
    logic signed [DW-1:0] e_dx, e_dy, dx2, dy2;
    logic signed [DW-1:0] d0, inc_a, inc_b;
    dec_test_t test;
    logic major_dec, minor_dec;
    logic [W-1:0] count;
    logic taken;

    assign dxr = $signed({1'b0, tgt_x_reg}) - $signed({1'b0, cur_x_reg});
    assign dyr = $signed({1'b0, tgt_y_reg}) - $signed({1'b0, cur_y_reg});
    assign adx = dxr[W] ? -dxr : dxr;
    assign ady = dyr[W] ? -dyr : dyr;
    assign dx_zero = (dxr == '0);
    assign dy_zero = (dyr == '0);
    assign dx_pos  = !dxr[W] && !dx_zero;
    assign dy_pos  = !dyr[W] && !dy_zero;
    assign same_sign = (dx_pos == dy_pos);

    assign oct_sr  = (dx_zero && dy_pos)
                   || (!dx_zero && !dy_zero && same_sign && (ady > adx));
    assign oct_shr = !oct_sr && !dx_zero && (dy_zero || same_sign);
    assign oct_shf = !oct_sr && !oct_shr && !dx_zero && (ady <= adx);
    assign major_y = !(oct_shr || oct_shf);

    assign swap = oct_sr ? dyr[W] : (major_y ? dy_pos : dxr[W]);
    assign odx  = swap ? -dxr : dxr;
    assign ody  = swap ? -dyr : dyr;
    assign e_dx = {{(DW-W-1){odx[W]}}, odx};
    assign e_dy = {{(DW-W-1){ody[W]}}, ody};
    assign dx2  = e_dx <<< 1;
    assign dy2  = e_dy <<< 1;
    assign count = major_y ? ady[W-1:0] : adx[W-1:0];

    always_comb
    begin
        priority if (oct_sr)
        begin
            d0 = dx2 - e_dy;  inc_a = dx2 - dy2;  inc_b = dx2;
            test = DEC_GE0;   major_dec = 1'b0;   minor_dec = 1'b0;
        end
        else if (oct_shr)
        begin
            d0 = e_dx - dy2;  inc_a = dx2 - dy2;  inc_b = -dy2;
            test = DEC_LT0;   major_dec = 1'b0;   minor_dec = 1'b0;
        end
        else if (oct_shf)
        begin
            d0 = -e_dx - dy2; inc_a = -dx2 - dy2; inc_b = -dy2;
            test = DEC_GT0;   major_dec = 1'b0;   minor_dec = 1'b1;
        end
        else
        begin
            d0 = -dx2 - e_dy; inc_a = -dx2 - dy2; inc_b = -dx2;
            test = DEC_LT0;   major_dec = 1'b1;   minor_dec = 1'b0;
        end
    end

    always_comb
    begin
        unique case (test_reg)
            DEC_GE0: taken = !d_reg[DW-1];
            DEC_LT0: taken = d_reg[DW-1];
            DEC_GT0: taken = !d_reg[DW-1] && (d_reg != '0);
            default: taken = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg <= '0;
            cur_y_reg <= '0;
        end
        else if (ctl.load_move)
        begin
            cur_x_reg <= x_coord;
            cur_y_reg <= y_coord;
        end
        else if (ctl.setup)
        begin
            cur_x_reg <= tgt_x_reg;
            cur_y_reg <= tgt_y_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_line)
        begin
            tgt_x_reg <= x_coord;
            tgt_y_reg <= y_coord;
        end
        if (ctl.setup)
        begin
            walk_x_reg    <= swap ? tgt_x_reg : cur_x_reg;
            walk_y_reg    <= swap ? tgt_y_reg : cur_y_reg;
            cnt_reg       <= count;
            d_reg         <= d0;
            inc_a_reg     <= inc_a;
            inc_b_reg     <= inc_b;
            test_reg      <= test;
            major_y_reg   <= major_y;
            major_dec_reg <= major_dec;
            minor_dec_reg <= minor_dec;
        end
        else if (ctl.step)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            d_reg   <= d_reg + (taken ? inc_a_reg : inc_b_reg);
            if (major_y_reg)
            begin
                walk_y_reg <= major_dec_reg ? walk_y_reg - 1'b1 : walk_y_reg + 1'b1;
                if (taken)
                begin
                    walk_x_reg <= walk_x_reg + 1'b1;
                end
            end
            else
            begin
                walk_x_reg <= walk_x_reg + 1'b1;
                if (taken)
                begin
                    walk_y_reg <= minor_dec_reg ? walk_y_reg - 1'b1 : walk_y_reg + 1'b1;
                end
            end
        end
        if (ctl.step)
        begin
            pix_x_reg    <= walk_x_reg;
            pix_y_reg    <= walk_y_reg;
            pix_last_reg <= (cnt_reg == W'(1));
        end
    end

    assign out_valid_next = ctl.step || (out_valid_reg && pixel_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign sts.zero_len  = dx_zero && dy_zero;
    assign sts.last_step = (cnt_reg == W'(1));
    assign sts.out_free  = !out_valid_reg || !pixel_stall;

    assign pixel_valid = out_valid_reg;
    assign pixel_x     = pix_x_reg;
    assign pixel_y     = pix_y_reg;
    assign last_pixel  = pix_last_reg;

    a_step_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.step |-> (!out_valid_reg || !pixel_stall))
        else $error("pixel overwritten while stalled");

    a_step_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.step |-> (cnt_reg != '0))
        else $error("step with no pixels left");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.step && cnt_reg == W'(1)) |=> (pixel_valid && last_pixel))
        else $error("final pixel not flagged");

endmodule

[bench/tb_top.sv]
// Self-checking bench for midpoint_line_rasterizer_unit: move and line requests in, pixels out.
// Predicts every pixel of every line and checks each one, under random bursts and stalls.
// Depends on mlr_pkg and the rasterizer RTL.
module tb_top;
    import mlr_pkg::*;

    localparam int CW          = COORD_BITS_DEF;
    localparam int MAX_C       = (1 << CW) - 1;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic          cmd;
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic          drain_first;
    } line_req_t;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic          last;
    } pixel_t;

    typedef enum logic [1:0] {
        STEEP_RISE,
        SHALLOW_RISE,
        SHALLOW_FALL,
        STEEP_FALL
    } octant_t;

    logic          clk         = 1'b0;
    logic          rst_n       = 1'b0;
    logic          cmd_valid   = 1'b0;
    logic          cmd_stall;
    logic          cmd         = CMD_MOVE;
    logic [CW-1:0] x_coord     = '0;
    logic [CW-1:0] y_coord     = '0;
    logic          pixel_valid;
    logic          pixel_stall = 1'b0;
    logic [CW-1:0] pixel_x;
    logic [CW-1:0] pixel_y;
    logic          last_pixel;

    line_req_t     pending_requests[$];
    pixel_t        expected_pixels[$];
    logic [CW-1:0] pen_x = '0;
    logic [CW-1:0] pen_y = '0;
    int            error_count = 0;
    int            cycle_count = 0;
    int            burst_left;
    int            gap_left;
    line_req_t     taken_req;
    pixel_t        want_pix;
    int            stall_mode;
    int            stall_run_left;
    logic          stall_bit = 1'b0;
    logic          long_hold = 1'b0;
    int            hold_count = 0;

    midpoint_line_rasterizer_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .cmd         (cmd),
        .x_coord     (x_coord),
        .y_coord     (y_coord),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .last_pixel  (last_pixel)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic plot(input int x, input int y, input bit last);
        pixel_t p;
        p.x = CW'(x);
        p.y = CW'(y);
        p.last = last;
        expected_pixels.push_back(p);
    endtask

    task automatic predict_line_pixels(input logic c, input logic [CW-1:0] tx,
                                       input logic [CW-1:0] ty);
        int      x0, y0, x1, y1, dx, dy, adx, ady, d, x, y, t;
        bit      same_sign;
        octant_t oct;
        x0 = pen_x;
        y0 = pen_y;
        x1 = tx;
        y1 = ty;
        dx = x1 - x0;
        dy = y1 - y0;
        adx = dx < 0 ? -dx : dx;
        ady = dy < 0 ? -dy : dy;
        same_sign = (dx > 0) == (dy > 0);
        if (c == CMD_LINE && !(dx == 0 && dy == 0))
        begin
            if ((dx == 0 && dy > 0) || (dx != 0 && dy != 0 && same_sign && ady > adx))
                oct = STEEP_RISE;
            else if (dx != 0 && (dy == 0 || same_sign))
                oct = SHALLOW_RISE;
            else if (dx != 0 && ady <= adx)
                oct = SHALLOW_FALL;
            else
                oct = STEEP_FALL;
            // order endpoints so the walk always runs the same way
            if ((oct == STEEP_RISE && y0 > y1) || (oct == STEEP_FALL && y0 < y1) ||
                ((oct == SHALLOW_RISE || oct == SHALLOW_FALL) && x0 > x1))
            begin
                t = x0; x0 = x1; x1 = t;
                t = y0; y0 = y1; y1 = t;
            end
            dx = x1 - x0;
            dy = y1 - y0;
            x = x0;
            y = y0;
            case (oct)
                STEEP_RISE:
                begin
                    d = 2 * dx - dy;
                    for (y = y0; y < y1; y++)
                    begin
                        plot(x, y, y + 1 == y1);
                        if (d >= 0)
                        begin
                            x++;
                            d += 2 * dx - 2 * dy;
                        end
                        else
                            d += 2 * dx;
                    end
                end
                SHALLOW_RISE:
                begin
                    d = dx - 2 * dy;
                    for (x = x0; x < x1; x++)
                    begin
                        plot(x, y, x + 1 == x1);
                        if (d < 0)
                        begin
                            y++;
                            d += 2 * dx - 2 * dy;
                        end
                        else
                            d -= 2 * dy;
                    end
                end
                SHALLOW_FALL:
                begin
                    d = -dx - 2 * dy;
                    for (x = x0; x < x1; x++)
                    begin
                        plot(x, y, x + 1 == x1);
                        if (d > 0)
                        begin
                            y--;
                            d -= 2 * dx + 2 * dy;
                        end
                        else
                            d -= 2 * dy;
                    end
                end
                default:
                begin
                    d = -2 * dx - dy;
                    for (y = y0; y > y1; y--)
                    begin
                        plot(x, y, y - 1 == y1);
                        if (d < 0)
                        begin
                            x++;
                            d -= 2 * dx + 2 * dy;
                        end
                        else
                            d -= 2 * dx;
                    end
                end
            endcase
        end
        if (!(c == CMD_LINE && dx == 0 && dy == 0))
        begin
            pen_x = tx;
            pen_y = ty;
        end
    endtask

    // driver: bursts of requests with random gaps, holding while stalled
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            burst_left = 1;
            gap_left = 0;
        end
        else
        begin
            if (cmd_valid && !cmd_stall)
            begin
                taken_req = pending_requests.pop_front();
                predict_line_pixels(taken_req.cmd, taken_req.x, taken_req.y);
            end
            if (!(cmd_valid && cmd_stall))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    cmd_valid <= 1'b0;
                end
                else if (pending_requests.size() != 0 &&
                         (!pending_requests[0].drain_first || expected_pixels.size() == 0))
                begin
                    cmd_valid <= 1'b1;
                    cmd       <= pending_requests[0].cmd;
                    x_coord   <= pending_requests[0].x;
                    y_coord   <= pending_requests[0].y;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(40, 1);
                        gap_left = ($urandom_range(9) < 3) ? 0 : $urandom_range(8, 1);
                    end
                end
                else
                    cmd_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off so the block backs up into the request side
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_count <= 0;
            long_hold  <= 1'b0;
        end
        else
        begin
            hold_count <= hold_count + 1;
            if (hold_count % 2500 == 1500)
                long_hold <= 1'b1;
            else if (hold_count % 2500 == 1800)
                long_hold <= 1'b0;
        end
    end

    // monitor: check each pixel taken, then pick the next stall value
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pixel_stall <= 1'b0;
            stall_mode = 0;
            stall_run_left = 0;
        end
        else
        begin
            if (pixel_valid && !pixel_stall)
            begin
                if (expected_pixels.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected pixel: x=%0d y=%0d last=%0b",
                                 pixel_x, pixel_y, last_pixel);
                end
                else
                begin
                    want_pix = expected_pixels.pop_front();
                    if (pixel_x !== want_pix.x || pixel_y !== want_pix.y ||
                        last_pixel !== want_pix.last)
                    begin
                        error_count++;
                        if (error_count <= 10)
                            $display("pixel mismatch: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                                     want_pix.x, want_pix.y, want_pix.last,
                                     pixel_x, pixel_y, last_pixel);
                    end
                end
            end
            if (stall_run_left <= 0)
            begin
                stall_mode = $urandom_range(3);
                stall_run_left = $urandom_range(200, 20);
            end
            else
                stall_run_left--;
            case (stall_mode)
                0:       stall_bit = 1'b0;
                1:       stall_bit = ($urandom_range(3) == 0);
                2:       stall_bit = ($urandom_range(3) != 0);
                default: stall_bit = ~stall_bit;
            endcase
            pixel_stall <= long_hold || stall_bit;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic add_request(input logic c, input int x, input int y, input bit drain);
        line_req_t r;
        r.cmd = c;
        r.x = CW'(x);
        r.y = CW'(y);
        r.drain_first = drain;
        pending_requests.push_back(r);
    endtask

    function automatic int near_coord(input int base);
        int t;
        t = base + int'($urandom_range(14)) - 7;
        if (t < 0)
            t = 0;
        if (t > MAX_C)
            t = MAX_C;
        return t;
    endfunction

    initial
    begin
        int   i, r, kind;
        int   nx, ny, gen_x, gen_y;
        logic c;

        add_request(CMD_LINE, 0, 0, 0);
        add_request(CMD_LINE, MAX_C, 0, 0);
        add_request(CMD_LINE, MAX_C, MAX_C, 0);
        add_request(CMD_LINE, 0, MAX_C, 0);
        add_request(CMD_LINE, 0, 0, 0);
        add_request(CMD_LINE, MAX_C, MAX_C, 0);
        add_request(CMD_MOVE, 10, 20, 1);
        add_request(CMD_LINE, 30, 25, 0);
        add_request(CMD_LINE, 15, 60, 0);
        add_request(CMD_LINE, 20, 5, 0);
        add_request(CMD_LINE, 60, 15, 0);
        add_request(CMD_LINE, 5, 40, 0);
        add_request(CMD_LINE, 8, 50, 0);
        add_request(CMD_LINE, 2, 30, 0);
        add_request(CMD_LINE, 40, 0, 0);
        add_request(CMD_LINE, 0, MAX_C, 0);
        add_request(CMD_LINE, MAX_C, 0, 0);
        add_request(CMD_LINE, MAX_C, 0, 0);
        add_request(CMD_MOVE, MAX_C, MAX_C, 0);
        add_request(CMD_LINE, MAX_C - 1, MAX_C - 1, 0);
        add_request(CMD_LINE, MAX_C, MAX_C - 1, 0);
        add_request(CMD_LINE, MAX_C, MAX_C, 0);
        gen_x = MAX_C;
        gen_y = MAX_C;

        for (i = 0; i < 400; i++)
        begin
            r = $urandom_range(99);
            c = (r < 15) ? CMD_MOVE : CMD_LINE;
            kind = $urandom_range(99);
            if (kind < 55)
            begin
                nx = near_coord(gen_x);
                ny = near_coord(gen_y);
            end
            else if (kind < 85)
            begin
                nx = $urandom_range(MAX_C);
                ny = $urandom_range(MAX_C);
            end
            else if (kind < 92)
            begin
                nx = $urandom_range(1) ? MAX_C : 0;
                ny = $urandom_range(1) ? MAX_C : 0;
            end
            else
            begin
                nx = gen_x;
                ny = gen_y;
                r = $urandom_range(2);
                if (r == 0)
                    ny = $urandom_range(MAX_C);
                else if (r == 1)
                    nx = $urandom_range(MAX_C);
            end
            add_request(c, nx, ny, (i % 100) == 50);
            gen_x = nx;
            gen_y = ny;
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_requests.size() != 0 || cmd_valid)
            @(posedge clk);
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
